>>> rtl/hsj_pkg.sv
package hsj_pkg;

  localparam int MAX_N     = 64;
  localparam int FRAC_BITS = 16;
  localparam int MIN_N     = 3;

  localparam int CELL_W     = 40;
  localparam int ACC_W      = 64;
  localparam int GS_W       = 7;
  localparam int ENERGY_W   = 16;
  localparam int COORD_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IDX_W    = $clog2(MAX_N);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int N_W      = $clog2(MAX_N + 1);
  localparam int LINE_LEN = 2 * MAX_N + 1;
  localparam int SUM_W    = CELL_W + 3;

  localparam int NUM_SRC = 3;
  localparam int SRC_W   = $clog2(NUM_SRC);

  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  localparam int GRID_SIZE_RESET     = 64;
  localparam int SOURCE_ENERGY_RESET = 1;

  // exact floor division of small values by multiply and shift
  localparam int S3 = N_W + 2;
  localparam int M3 = ((1 << S3) + 2) / 3;
  localparam int S5 = N_W + 5;
  localparam int M5 = ((1 << S5) + 4) / 5;
  localparam int S9 = N_W + 7;
  localparam int M9 = ((1 << S9) + 8) / 9;

  localparam logic CMD_ITER  = 1'b0;
  localparam logic CMD_READ  = 1'b1;
  localparam logic KIND_ITER = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ENERGY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_INJ_RD,
    ST_INJ_WR,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/hsj_ram.sv
module hsj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/heat_stencil_jacobi_2d_core.sv
// Five-point Jacobi heat stencil over an n by n grid (n = grid_size, clamped to 3..64) of
// unsigned Q24.16 cells with a zero halo, plus a saturating Q48.16 heat total. Two grid
// banks live in single-port-read RAMs; an iteration streams the current bank in raster
// order at a fixed row stride of 64, one RAM read per cycle, through a two-row shift line,
// writes the new bank, then read-modify-writes the three source cells and swaps banks.
// An iteration's length is set by the single read port of the current bank. After reset
// both banks are zeroed by a clearing pass over all 4096 addresses during which no command
// is taken (register writes still are). One result per command; the next command is taken
// while the last result awaits transfer.
module heat_stencil_jacobi_2d_core
  import hsj_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [COORD_W-1:0]    column,
  input  logic [COORD_W-1:0]    row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  result_kind,
  output logic [ACC_W-1:0]      heat_sum,
  output logic [CELL_W-1:0]     cell_value
);

  state_t state, state_next;

  logic [GS_W-1:0]     grid_size;
  logic [ENERGY_W-1:0] source_energy;
  logic [N_W-1:0]      n_act;

  logic [ADDR_W-1:0] clear_addr;
  logic              cur_bank;
  logic [ACC_W-1:0]  heat_acc, heat_acc_next;

  logic [N_W-1:0]   rd_row;
  logic [IDX_W-1:0] rd_col;
  logic             d1_valid;
  logic [N_W-1:0]   d1_row;
  logic [IDX_W-1:0] d1_col;
  logic             rd_bank, rd_bank_next;

  logic [CELL_W-1:0] line [LINE_LEN];
  logic              s_valid;
  logic [N_W-1:0]    s_row;
  logic [IDX_W-1:0]  s_col;

  logic              p_valid;
  logic [ADDR_W-1:0] p_addr;
  logic [SUM_W-1:0]  p_sum;

  logic [ADDR_W-1:0] src_addr [NUM_SRC];
  logic [ADDR_W-1:0] src_addr_next [NUM_SRC];
  logic [SRC_W-1:0]  inj_idx;

  logic              res_kind;
  logic [CELL_W-1:0] res_cell;
  logic              rd_in_range, cmd_in_range;
  logic [ADDR_W-1:0] cmd_addr;

  logic [ADDR_W-1:0] ram_raddr, ram_waddr;
  logic [CELL_W-1:0] ram_wdata, rdata_even, rdata_odd, rd_data;
  logic              wr_en, wr_both, wr_bank, we_even, we_odd;
  logic              load_out;

  logic              cell_ok, up_ok, down_ok, left_ok, right_ok;
  logic [N_W-1:0]    c_row;
  logic [SUM_W-1:0]  c_sum;
  logic [CELL_W-1:0] new_val;
  logic [ACC_W:0]    heat_add;

  logic [ACC_W-1:0]  amt_wide;
  logic [CELL_W-1:0] amount;
  logic [CELL_W:0]   inj_sum;
  logic [CELL_W-1:0] inj_val;

  logic [31:0] q2, q3, q45, q89;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [31:0] r1, input logic [31:0] c1);
    return {IDX_W'(r1 - 32'd1), IDX_W'(c1 - 32'd1)};
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= GS_W'(GRID_SIZE_RESET);
      source_energy <= ENERGY_W'(SOURCE_ENERGY_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_SIZE:     grid_size     <= cfg_data[GS_W-1:0];
        REG_SOURCE_ENERGY: source_energy <= cfg_data[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(grid_size) < MIN_N) begin
      n_act = N_W'(MIN_N);
    end else if (int'(grid_size) > MAX_N) begin
      n_act = N_W'(MAX_N);
    end else begin
      n_act = N_W'(grid_size);
    end
  end

  // source cells
  always_comb begin
    q2  = 32'(n_act) >> 1;
    q3  = (32'(n_act) * 32'(M3)) >> S3;
    q45 = (32'(n_act) * 32'd4 * 32'(M5)) >> S5;
    q89 = (32'(n_act) * 32'd8 * 32'(M9)) >> S9;
    src_addr_next[0] = cell_addr(q2, q2);
    src_addr_next[1] = cell_addr(q3, q3);
    src_addr_next[2] = cell_addr(q89, q45);
  end

  // read command decode
  always_comb begin
    cmd_in_range = (row != '0) && (column != '0) &&
                   (int'(row) <= int'(n_act)) && (int'(column) <= int'(n_act));
    cmd_addr     = {IDX_W'(row - COORD_W'(1)), IDX_W'(column - COORD_W'(1))};
  end

  // injection amount and update
  always_comb begin
    amt_wide = ACC_W'(source_energy) << FRAC_BITS;
    amount   = (amt_wide > ACC_W'(CELL_MAX)) ? CELL_MAX : amt_wide[CELL_W-1:0];
    inj_sum  = {1'b0, rd_data} + {1'b0, amount};
    inj_val  = inj_sum[CELL_W] ? CELL_MAX : inj_sum[CELL_W-1:0];
  end

  // stencil stage on the shift line taps
  always_comb begin
    c_row    = s_row - N_W'(1);
    cell_ok  = s_valid && (s_row != '0) && (N_W'(s_col) < n_act);
    up_ok    = (s_row != N_W'(1));
    down_ok  = (s_row != n_act);
    left_ok  = (s_col != '0);
    right_ok = (N_W'(s_col) != n_act - N_W'(1));
    c_sum    = {1'b0, line[MAX_N], 2'b00}
             + (up_ok    ? SUM_W'(line[2*MAX_N])   : '0)
             + (down_ok  ? SUM_W'(line[0])         : '0)
             + (left_ok  ? SUM_W'(line[MAX_N+1])   : '0)
             + (right_ok ? SUM_W'(line[MAX_N-1])   : '0)
             + SUM_W'(4);
  end

  always_comb begin
    new_val  = p_sum[SUM_W-1:3];
    heat_add = {1'b0, heat_acc} + (ACC_W+1)'(new_val);
    heat_acc_next = heat_add[ACC_W] ? '1 : heat_add[ACC_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (cmd == CMD_READ) ? ST_READ : ST_SCAN;
      end
      ST_READ: state_next = ST_FINISH;
      ST_SCAN: begin
        if (rd_row == n_act && rd_col == IDX_W'(MAX_N - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!d1_valid && !s_valid && !p_valid) state_next = ST_INJ_RD;
      end
      ST_INJ_RD: state_next = ST_INJ_WR;
      ST_INJ_WR: begin
        state_next = (inj_idx == SRC_W'(NUM_SRC - 1)) ? ST_FINISH : ST_INJ_RD;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_ready     = 1'b0;
    load_out     = 1'b0;
    ram_raddr    = cmd_addr;
    rd_bank_next = cur_bank;
    wr_en        = p_valid;
    wr_both      = 1'b0;
    wr_bank      = ~cur_bank;
    ram_waddr    = p_addr;
    ram_wdata    = new_val;
    unique case (state)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_both   = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: ram_raddr = {rd_row[IDX_W-1:0], rd_col};
      ST_INJ_RD: begin
        ram_raddr    = src_addr[inj_idx];
        rd_bank_next = ~cur_bank;
      end
      ST_INJ_WR: begin
        wr_en     = 1'b1;
        ram_waddr = src_addr[inj_idx];
        ram_wdata = inj_val;
      end
      ST_FINISH: load_out = !out_valid || out_ready;
      default: ;
    endcase
    we_even = wr_en && (wr_both || !wr_bank);
    we_odd  = wr_en && (wr_both || wr_bank);
  end

  assign rd_data = rd_bank ? rdata_odd : rdata_even;

  hsj_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_grid_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_even)
  );

  hsj_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_grid_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata_odd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      cur_bank   <= 1'b0;
      heat_acc   <= '0;
      rd_row     <= '0;
      rd_col     <= '0;
      inj_idx    <= '0;
      d1_valid   <= 1'b0;
      s_valid    <= 1'b0;
      p_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      d1_valid <= (state == ST_SCAN);
      s_valid  <= d1_valid;
      p_valid  <= cell_ok;
      if (state == ST_CLEAR) clear_addr <= clear_addr + ADDR_W'(1);
      if (p_valid) heat_acc <= heat_acc_next;
      if (state == ST_IDLE) begin
        rd_row  <= '0;
        rd_col  <= '0;
        inj_idx <= '0;
      end else if (state == ST_SCAN) begin
        if (rd_col == IDX_W'(MAX_N - 1)) begin
          rd_col <= '0;
          rd_row <= rd_row + N_W'(1);
        end else begin
          rd_col <= rd_col + IDX_W'(1);
        end
      end else if (state == ST_INJ_WR) begin
        inj_idx <= inj_idx + SRC_W'(1);
        if (inj_idx == SRC_W'(NUM_SRC - 1)) cur_bank <= ~cur_bank;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_bank <= rd_bank_next;
    d1_row  <= rd_row;
    d1_col  <= rd_col;
    if (d1_valid) begin
      line[0] <= rd_data;
      for (int i = 1; i < LINE_LEN; i++) begin
        line[i] <= line[i-1];
      end
      s_row <= d1_row;
      s_col <= d1_col;
    end
    p_addr <= {c_row[IDX_W-1:0], s_col};
    p_sum  <= c_sum;
    if (state == ST_IDLE && in_valid) begin
      res_kind    <= cmd;
      res_cell    <= '0;
      rd_in_range <= cmd_in_range;
      for (int k = 0; k < NUM_SRC; k++) begin
        src_addr[k] <= src_addr_next[k];
      end
    end
    if (state == ST_READ) res_cell <= rd_in_range ? rd_data : '0;
    if (load_out) begin
      result_kind <= res_kind;
      heat_sum    <= heat_acc;
      cell_value  <= res_cell;
    end
  end

  // stencil writes never collide with the source cell updates
  assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("stencil write outside the scan");

  // the last source update swaps the banks
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_INJ_WR && inj_idx == SRC_W'(NUM_SRC - 1)) |=> (cur_bank != $past(cur_bank)))
    else $error("bank swap missed");

  // heat total never falls
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (heat_acc >= $past(heat_acc)))
    else $error("heat total decreased");

  // a result transfer is loaded only from the finishing step
  assert property (@(posedge clk) disable iff (rst)
    (!$past(out_valid) && out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish");

endmodule
